@@ hw/rtl/dda_pkg.sv @@
// ----------------------------------------------------------------------------
// DDA line rasterizer package
// Shared widths, item codes and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package dda_pkg;

	localparam int COORD_BITS   = 10;
	localparam int FRAC_BITS    = 16;
	localparam int POS_BITS     = COORD_BITS + FRAC_BITS;
	localparam int INC_BITS     = FRAC_BITS + 2;
	localparam int STEP_BITS    = COORD_BITS + 1;
	localparam int QUO_BITS     = FRAC_BITS + 1;
	localparam int CNT_BITS     = $clog2(FRAC_BITS + 1);
	localparam int IN_DATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

	// Item kinds carried on the input tuser bit.
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_NEXT  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DIV  = 2'b10
	} state_t;

	typedef struct packed {
		logic load;     // latch a new line and show its first pixel
		logic step;     // advance one pixel and show it
		logic div_run;  // one iteration of the serial divider
	} cmd_t;

	typedef struct packed {
		logic zero_len; // endpoints of the presented item coincide
		logic active;   // a line still has pixels to give
		logic div_last; // divider is on its final iteration
	} status_t;

endpackage

@@ hw/rtl/dda_ctrl.sv @@
// ----------------------------------------------------------------------------
// DDA controller
// Handshake control, divider sequencing and output valid flag.
// ----------------------------------------------------------------------------
module dda_ctrl
	import dda_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	input  logic    s_tuser,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;

	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd.load    = accept && (s_tuser == KIND_START);
		cmd.step    = accept && (s_tuser == KIND_NEXT) && status.active;
		cmd.div_run = (state_q == ST_DIV);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load && !status.zero_len) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (status.div_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load || cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hw/rtl/dda_datapath.sv @@
// ----------------------------------------------------------------------------
// DDA datapath
// Endpoint deltas, serial restoring divider, position accumulators and the
// output register.
// ----------------------------------------------------------------------------
module dda_datapath
	import dda_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [IN_DATA_BITS-1:0]   s_tdata,
	input  cmd_t                      cmd,
	output status_t                   status,
	output logic [OUT_DATA_BITS-1:0]  m_tdata,
	output logic                      m_tlast
);

	localparam logic [QUO_BITS-1:0] ONE_MAG = QUO_BITS'(1) << FRAC_BITS;

	function automatic logic [INC_BITS-1:0] make_inc(input logic [QUO_BITS-1:0] mag,
		input logic neg);
		logic [INC_BITS-1:0] m;
		m = {{(INC_BITS - QUO_BITS){1'b0}}, mag};
		return neg ? (~m + INC_BITS'(1)) : m;
	endfunction

	logic [COORD_BITS-1:0] sx, sy, ex, ey;
	logic                  xneg, yneg, x_major;
	logic [COORD_BITS-1:0] adx, ady, major, minor;

	logic [POS_BITS-1:0]   pos_x_q, pos_y_q, pos_x_d, pos_y_d;
	logic [INC_BITS-1:0]   inc_x_q, inc_y_q;
	logic [STEP_BITS-1:0]  steps_q, steps_d;
	logic                  active_q;

	logic [COORD_BITS-1:0] major_q;
	logic [STEP_BITS-1:0]  rem_q, rem_sh, rem_d;
	logic [QUO_BITS-1:0]   quo_q, quo_d;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  x_major_q, major_neg_q, minor_neg_q, ge;

	logic [COORD_BITS-1:0] px_q, py_q;
	logic                  last_q;

	assign sx = s_tdata[COORD_BITS-1:0];
	assign sy = s_tdata[2*COORD_BITS-1:COORD_BITS];
	assign ex = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
	assign ey = s_tdata[4*COORD_BITS-1:3*COORD_BITS];

	always_comb begin
		xneg    = ex < sx;
		yneg    = ey < sy;
		adx     = xneg ? (sx - ex) : (ex - sx);
		ady     = yneg ? (sy - ey) : (ey - sy);
		x_major = adx > ady;
		major   = x_major ? adx : ady;
		minor   = x_major ? ady : adx;
	end

	// The first iteration yields the integer quotient bit (minor never exceeds
	// major); each later one shifts the partial remainder and brings in a zero.
	always_comb begin
		rem_sh = (cnt_q == CNT_BITS'(FRAC_BITS)) ? rem_q : {rem_q[STEP_BITS-2:0], 1'b0};
		ge     = rem_sh >= {1'b0, major_q};
		rem_d  = ge ? (rem_sh - {1'b0, major_q}) : rem_sh;
		quo_d  = {quo_q[QUO_BITS-2:0], ge};
	end

	always_comb begin
		pos_x_d = pos_x_q + {{(POS_BITS - INC_BITS){inc_x_q[INC_BITS-1]}}, inc_x_q};
		pos_y_d = pos_y_q + {{(POS_BITS - INC_BITS){inc_y_q[INC_BITS-1]}}, inc_y_q};
		steps_d = steps_q - STEP_BITS'(1);
	end

	always_comb begin
		status.zero_len = (sx == ex) && (sy == ey);
		status.active   = active_q;
		status.div_last = (cnt_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (cmd.load) begin
				active_q <= !status.zero_len;
				cnt_q    <= CNT_BITS'(FRAC_BITS);
			end else if (cmd.step) begin
				active_q <= (steps_d != '0);
			end else if (cmd.div_run) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_x_q     <= {sx, {FRAC_BITS{1'b0}}};
			pos_y_q     <= {sy, {FRAC_BITS{1'b0}}};
			steps_q     <= {1'b0, major};
			major_q     <= major;
			rem_q       <= {1'b0, minor};
			quo_q       <= '0;
			x_major_q   <= x_major;
			major_neg_q <= x_major ? xneg : yneg;
			minor_neg_q <= x_major ? yneg : xneg;
			px_q        <= sx;
			py_q        <= sy;
			last_q      <= status.zero_len;
		end else if (cmd.step) begin
			pos_x_q <= pos_x_d;
			pos_y_q <= pos_y_d;
			steps_q <= steps_d;
			px_q    <= pos_x_d[POS_BITS-1:FRAC_BITS];
			py_q    <= pos_y_d[POS_BITS-1:FRAC_BITS];
			last_q  <= (steps_d == '0);
		end else if (cmd.div_run) begin
			rem_q <= rem_d;
			quo_q <= quo_d;
			if (status.div_last) begin
				if (x_major_q) begin
					inc_x_q <= make_inc(ONE_MAG, major_neg_q);
					inc_y_q <= make_inc(quo_d, minor_neg_q);
				end else begin
					inc_y_q <= make_inc(ONE_MAG, major_neg_q);
					inc_x_q <= make_inc(quo_d, minor_neg_q);
				end
			end
		end
	end

	assign m_tdata = {{(OUT_DATA_BITS - 2 * COORD_BITS){1'b0}}, py_q, px_q};
	assign m_tlast = last_q;

endmodule

@@ hw/rtl/dda_line_rasterizer.sv @@
// ----------------------------------------------------------------------------
// DDA line rasterizer
// Steps a line between two endpoints one pixel per item, using fixed-point
// accumulators and a serial divider for the minor-axis slope.
// ----------------------------------------------------------------------------
// A start item (tuser low) carries two endpoints and returns the first pixel
// of the line at once, on the cycle after it is taken. The slope of the minor
// axis is then found by a bit-serial restoring divider that gives one quotient
// bit per cycle, and the input stays not ready until the final quotient bit is
// in. A line whose endpoints coincide needs no divide and returns its single
// pixel, marked last, without that pause. A next item (tuser high) advances
// both position accumulators by one add each and is taken every cycle while
// no divide runs and the result side keeps up; the output register lets a new
// item enter in the same cycle as the previous pixel leaves. A next item with
// no line in progress is taken and gives no pixel. The major axis is the one
// with the larger delta, y on a tie; it moves one whole pixel per step while
// the other axis moves by the truncated quotient, and the pixel shown is the
// integer part of each position. The last pixel of a line carries tlast. A
// start item abandons any line in progress.
module dda_line_rasterizer
	import dda_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IN_DATA_BITS-1:0]  s_tdata,   // start_x, start_y, end_x, end_y
	input  logic                     s_tuser,   // kind
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_DATA_BITS-1:0] m_tdata,   // pixel_x, pixel_y, zero padding
	output logic                     m_tlast
);

	cmd_t    cmd;
	status_t status;

	// Sequencing: handshakes, divider run and output valid.
	dda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Arithmetic: deltas, divider, accumulators and the pixel register.
	dda_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.cmd     (cmd),
		.status  (status),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

@@ hw/rtl/dda_chk.sv @@
// ----------------------------------------------------------------------------
// DDA line rasterizer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module dda_chk
	import dda_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     s_tvalid,
	input logic                     s_tready,
	input logic [IN_DATA_BITS-1:0]  s_tdata,
	input logic                     s_tuser,
	input logic                     m_tvalid,
	input logic                     m_tready,
	input logic [OUT_DATA_BITS-1:0] m_tdata,
	input logic                     m_tlast
);

	logic start_acc, same_pts;

	assign start_acc = s_tvalid && s_tready && (s_tuser == KIND_START);
	assign same_pts  = (s_tdata[COORD_BITS-1:0] == s_tdata[3*COORD_BITS-1:2*COORD_BITS])
		&& (s_tdata[2*COORD_BITS-1:COORD_BITS] == s_tdata[4*COORD_BITS-1:3*COORD_BITS]);

	// A stalled pixel holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("pixel changed while stalled");

	// A start item returns its first endpoint on the next cycle.
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		start_acc |=> m_tvalid
			&& (m_tdata[2*COORD_BITS-1:0] == $past(s_tdata[2*COORD_BITS-1:0])))
		else $error("first pixel is not the start point");

	// A point-sized line is one pixel, flagged last.
	a_point: assert property (@(posedge clk) disable iff (!arst_n)
		start_acc && same_pts |=> m_tlast)
		else $error("single-point line not marked last");

	// A real line does not end on its first pixel, and the input is not ready as the divide begins.
	a_line: assert property (@(posedge clk) disable iff (!arst_n)
		start_acc && !same_pts |=> !m_tlast && !s_tready)
		else $error("line start mishandled");

endmodule

bind dda_line_rasterizer dda_chk u_chk (.*);

@@ test/dda_line_rasterizer_checker.sv @@
// ----------------------------------------------------------------------------
// DDA line rasterizer checker
// Watches both streams of the rasterizer and predicts every pixel from the
// accepted input items. It then compares each pixel that leaves the block
// against the oldest pixel still owed.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_checker
	import dda_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	input  logic                     s_tready,
	input  logic [IN_DATA_BITS-1:0]  s_tdata,   // start_x, start_y, end_x, end_y
	input  logic                     s_tuser,   // kind
	input  logic                     m_tvalid,
	input  logic                     m_tready,
	input  logic [OUT_DATA_BITS-1:0] m_tdata,   // pixel_x, pixel_y, zero padding
	input  logic                     m_tlast,
	output int                       fail_count,
	output int                       pending_count,
	output int                       pixel_count
);

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic                  last;
	} pixel_t;

	localparam logic [POS_BITS-1:0] ONE_PIXEL = POS_BITS'(1) << FRAC_BITS;

	// Shadow copy of the line state inside the block.
	logic [POS_BITS-1:0]  pos_x;
	logic [POS_BITS-1:0]  pos_y;
	logic [INC_BITS-1:0]  inc_x;
	logic [INC_BITS-1:0]  inc_y;
	logic [STEP_BITS-1:0] line_steps;
	logic                 line_active;

	pixel_t owed_pixels[$];
	int     mismatches;
	int     pixels_seen;

	function automatic logic [INC_BITS-1:0] signed_step(input logic [POS_BITS-1:0] mag,
			input logic neg);
		logic [INC_BITS-1:0] m;
		m = mag[INC_BITS-1:0];
		return neg ? -m : m;
	endfunction

	// Advances the shadow state by one accepted item; returns 1 when it yields a pixel.
	function automatic bit rasterize_item(input logic kind, input logic [IN_DATA_BITS-1:0] data,
			output pixel_t px);
		logic [COORD_BITS-1:0] x1, y1, x2, y2, adx, ady;
		logic                  xneg, yneg;
		logic [POS_BITS-1:0]   quo;
		px = '0;
		if (kind == KIND_START) begin
			x1 = data[0 +: COORD_BITS];
			y1 = data[COORD_BITS +: COORD_BITS];
			x2 = data[2*COORD_BITS +: COORD_BITS];
			y2 = data[3*COORD_BITS +: COORD_BITS];
			xneg = x2 < x1;
			yneg = y2 < y1;
			adx = xneg ? x1 - x2 : x2 - x1;
			ady = yneg ? y1 - y2 : y2 - y1;
			if (adx > ady) begin
				line_steps = STEP_BITS'(adx);
				quo = (POS_BITS'(ady) << FRAC_BITS) / POS_BITS'(adx);
				inc_x = signed_step(ONE_PIXEL, xneg);
				inc_y = signed_step(quo, yneg);
			end else if (ady != 0) begin
				line_steps = STEP_BITS'(ady);
				quo = (POS_BITS'(adx) << FRAC_BITS) / POS_BITS'(ady);
				inc_y = signed_step(ONE_PIXEL, yneg);
				inc_x = signed_step(quo, xneg);
			end else begin
				// Both endpoints coincide: a single pixel and no slope at all.
				line_steps = '0;
				inc_x = '0;
				inc_y = '0;
			end
			pos_x = POS_BITS'(x1) << FRAC_BITS;
			pos_y = POS_BITS'(y1) << FRAC_BITS;
		end else begin
			if (!line_active)
				return 0;
			pos_x = pos_x + {{(POS_BITS-INC_BITS){inc_x[INC_BITS-1]}}, inc_x};
			pos_y = pos_y + {{(POS_BITS-INC_BITS){inc_y[INC_BITS-1]}}, inc_y};
			line_steps = line_steps - 1'b1;
		end
		line_active = line_steps != 0;
		px.x = pos_x[FRAC_BITS +: COORD_BITS];
		px.y = pos_y[FRAC_BITS +: COORD_BITS];
		px.last = !line_active;
		return 1;
	endfunction

	always @(posedge clk) begin
		pixel_t got;
		pixel_t want;
		if (!arst_n) begin
			pos_x = '0;
			pos_y = '0;
			inc_x = '0;
			inc_y = '0;
			line_steps = '0;
			line_active = 1'b0;
			owed_pixels.delete();
			mismatches = 0;
			pixels_seen = 0;
		end else begin
			// The output side goes first: a pixel can never leave on the edge
			// at which the item that causes it is taken.
			if (m_tvalid && m_tready) begin
				got.x = m_tdata[0 +: COORD_BITS];
				got.y = m_tdata[COORD_BITS +: COORD_BITS];
				got.last = m_tlast;
				pixels_seen++;
				if (owed_pixels.size() == 0) begin
					$error("pixel (%0d,%0d) arrived with none predicted", got.x, got.y);
					mismatches++;
				end else begin
					want = owed_pixels.pop_front();
					if (got.x !== want.x) begin
						$error("pixel_x: expected %0d, actual %0d", want.x, got.x);
						mismatches++;
					end
					if (got.y !== want.y) begin
						$error("pixel_y: expected %0d, actual %0d", want.y, got.y);
						mismatches++;
					end
					if (got.last !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, got.last);
						mismatches++;
					end
					if (m_tdata[OUT_DATA_BITS-1:2*COORD_BITS] !== '0) begin
						$error("padding: expected 0, actual %0h",
							m_tdata[OUT_DATA_BITS-1:2*COORD_BITS]);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (rasterize_item(s_tuser, s_tdata, want))
					owed_pixels.push_back(want);
			end
		end
		fail_count <= mismatches;
		pending_count <= owed_pixels.size();
		pixel_count <= pixels_seen;
	end

endmodule

@@ test/dda_line_rasterizer_test.sv @@
// ----------------------------------------------------------------------------
// DDA line rasterizer testbench
// Drives start and next items into the rasterizer under three idling regimes
// and a long output stall, while a checker beside the block predicts and
// compares every pixel. Ends with a single verdict.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_test;
	import dda_pkg::*;

	localparam int HOLD_CYCLES    = 300;   // long output stall for back-pressure
	localparam int WATCHDOG_LIMIT = 2000;  // cycles without any item moving
	localparam int ITEMS_PER_PHASE = 430;
	localparam int SETTLE_CYCLES  = 40;    // a divide plus margin

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata;
	logic                     s_tuser;
	logic                     m_tvalid;
	logic                     m_tready;
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic                     m_tlast;

	int fail_count;
	int pending_count;
	int pixel_count;

	int send_idle_pct;
	int recv_idle_pct;
	int hold_requests;
	int items_sent;
	int starts_sent;
	int nexts_sent;
	int quiet_cycles;

	dda_line_rasterizer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	dda_line_rasterizer_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.pixel_count   (pixel_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Receiver: idles at random at the current rate, and on request holds off
	// for a long stretch so that the block backs up into its input.
	initial begin
		int hold_left;
		int served;
		m_tready = 1'b0;
		hold_left = 0;
		served = 0;
		forever begin
			@(posedge clk);
			if (served != hold_requests) begin
				served = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: any cycle in which neither side moves an item counts towards
	// the limit; the run is abandoned once it is reached.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [IN_DATA_BITS-1:0] pack_line(input int x1, input int y1,
			input int x2, input int y2);
		return {COORD_BITS'(y2), COORD_BITS'(x2), COORD_BITS'(y1), COORD_BITS'(x1)};
	endfunction

	function automatic int clamp_coord(input int v);
		return (v < 0) ? 0 : (v > 1023) ? 1023 : v;
	endfunction

	// Start points sit on the border of the grid now and then.
	function automatic int pick_coord();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 1) ? 1023 : 0;
		return $urandom_range(0, 1023);
	endfunction

	// Offers one item, after a random idle gap, and returns at the edge that
	// takes it.
	task automatic send_item(input logic kind, input logic [IN_DATA_BITS-1:0] data);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= data;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
		if (kind == KIND_START)
			starts_sent++;
		else
			nexts_sent++;
	endtask

	task automatic send_next();
		send_item(KIND_NEXT, IN_DATA_BITS'({$urandom, $urandom}));
	endtask

	task automatic send_line(input int x1, input int y1, input int x2, input int y2,
			input int nexts);
		send_item(KIND_START, pack_line(x1, y1, x2, y2));
		repeat (nexts)
			send_next();
	endtask

	// Stops offering and waits until every predicted pixel has come out.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
	endtask

	// One random line: mostly short, sometimes medium, now and then spanning
	// the grid. Most lines are walked to the end, some are cut short by the
	// next start, and a few see extra next items with no line left.
	task automatic random_line();
		int x1, y1, x2, y2, span, len, nexts, pick;
		x1 = pick_coord();
		y1 = pick_coord();
		pick = $urandom_range(0, 99);
		if (pick < 80)
			span = 15;
		else if (pick < 95)
			span = 100;
		else
			span = 1023;
		x2 = clamp_coord(x1 + $urandom_range(0, 2 * span) - span);
		y2 = clamp_coord(y1 + $urandom_range(0, 2 * span) - span);
		len = (x2 > x1 ? x2 - x1 : x1 - x2);
		if ((y2 > y1 ? y2 - y1 : y1 - y2) > len)
			len = (y2 > y1 ? y2 - y1 : y1 - y2);
		pick = $urandom_range(0, 99);
		if (pick < 70)
			nexts = len;
		else if (pick < 90)
			nexts = $urandom_range(0, len);
		else
			nexts = $urandom_range(0, 3);
		if (nexts > 60)
			nexts = 60;
		if (pick < 70 && $urandom_range(0, 3) == 0)
			nexts++;
		send_line(x1, y1, x2, y2, nexts);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = KIND_START;
		s_tdata = '0;
		send_idle_pct = 7;
		recv_idle_pct = 66;
		hold_requests = 0;
		items_sent = 0;
		starts_sent = 0;
		nexts_sent = 0;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A next item before any line gives no pixel.
		send_item(KIND_NEXT, '1);
		// Zero-length lines at both corners of the grid.
		send_line(0, 0, 0, 0, 0);
		send_line(1023, 1023, 1023, 1023, 0);
		// Flat line along x, abandoned by the following start.
		send_line(0, 0, 1023, 0, 2);
		// Diagonals in three directions; a tie makes y the major axis.
		send_line(1023, 0, 0, 1023, 1);
		send_line(1023, 1023, 0, 0, 1);
		send_line(0, 1023, 1023, 0, 1);
		// Short line walked to its end, then a next with nothing in progress.
		send_line(0, 0, 3, 1, 4);
		// Steep line with negative x, walked to its end.
		send_line(7, 2, 3, 9, 7);

		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				send_idle_pct <= 66;
				recv_idle_pct <= 7;
			end else if (phase == 2) begin
				send_idle_pct <= 0;
				recv_idle_pct <= 0;
				// Hold the output off while next items keep coming, so that
				// the block fills up and refuses input.
				hold_requests <= hold_requests + 1;
				send_line(0, 0, 1000, 400, 40);
			end
			while (items_sent < (phase + 1) * ITEMS_PER_PHASE)
				random_line();
			// Sender pauses until every pixel owed has arrived.
			drain();
		end

		repeat (SETTLE_CYCLES)
			@(posedge clk);
		$display("Covered %0d start and %0d next items, %0d pixels compared,", starts_sent,
			nexts_sent, pixel_count);
		$display("under three idling regimes and one long output stall.");
		if (fail_count == 0 && pending_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
